// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
// No dependencies; imported by every module under src.
package tcw_pkg;

  localparam int CELL_W = 11;
  localparam int DATA_W = 16;
  localparam int QDEPTH = 2;
  localparam int TAB_SPACES = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  // register indexes on the configuration port
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_BS,
    OP_LF,
    OP_TAB
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } q_entry_t;

endpackage

// ===== src/tcw_front.sv =====
// Front end: takes character requests, drops NUL, decodes the control codes.
// Depends on tcw_pkg; feeds tcw_fifo.
module tcw_front
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  output q_entry_t   q_wdata,
  output logic       q_push,
  input  logic       q_full
);

  op_t op;

  always_comb begin
    case (in_char_code)
      CH_BS:   op = OP_BS;
      CH_LF:   op = OP_LF;
      CH_TAB:  op = OP_TAB;
      default: op = OP_PRINT;
    endcase
  end

  assign in_ready   = ~q_full;
  assign q_wdata.op = op;
  assign q_wdata.ch = in_char_code;
  // NUL is consumed here and never reaches the back end
  assign q_push     = in_valid & ~q_full & (in_char_code != CH_NUL);

`ifndef SYNTHESIS
  a_no_nul_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.ch != CH_NUL))
    else $error("NUL pushed to queue");
`endif

endmodule

// ===== src/tcw_fifo.sv =====
// Two-entry request queue between the front and back ends.
// Depends on tcw_pkg.
module tcw_fifo
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  q_entry_t wdata,
  output logic     rvalid,
  output q_entry_t rdata,
  input  logic     pop
);

  localparam int PW = $clog2(QDEPTH);

  q_entry_t          mem_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]       cnt_r, cnt_nxt;

  assign full   = (cnt_r == (PW+1)'(QDEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== src/tcw_back.sv =====
// Back end: cursor state, cell address/data generation and result register.
// Depends on tcw_pkg; drains tcw_fifo.
module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        fg_attr,
  input  logic [3:0]        bg_attr,
  input  logic              q_valid,
  input  q_entry_t          q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_cell_write,
  output logic [CELL_W-1:0] out_cell_address,
  output logic [DATA_W-1:0] out_cell_data,
  output logic [CELL_W-1:0] out_cursor_pos,
  output logic              out_last
);

  // reset row is 2, so the row counter must hold at least 0..2
  localparam int RMAX = (ROWS > 3) ? ROWS : 3;
  localparam int RW   = $clog2(RMAX);
  localparam int CW   = $clog2(COLUMNS);
  localparam int IW   = $clog2(RMAX * COLUMNS);
  localparam int TW   = $clog2(TAB_SPACES);

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [IW-1:0] base_r, base_nxt;   // row_r * COLUMNS, kept incrementally
  logic [TW-1:0] tab_cnt_r, tab_cnt_nxt;

  logic              out_valid_r;
  logic              wr_r;
  logic [CELL_W-1:0] addr_r;
  logic [DATA_W-1:0] data_r;
  logic [CELL_W-1:0] cur_r;
  logic              last_r;

  logic              emit;
  logic              tab_end;
  logic [IW-1:0]     idx, idx_after;
  logic              e_wr;
  logic [IW-1:0]     e_addr;
  logic [7:0]        e_ch;
  logic              e_last;
  logic [IW+CELL_W-1:0] addr_ext, cur_ext;
  logic [7:0]        attr;
  logic [RW-1:0]     adv_row;
  logic [IW-1:0]     adv_base;

  assign emit    = q_valid & (~out_valid_r | out_ready);
  assign tab_end = (tab_cnt_r == TW'(TAB_SPACES-1));
  assign q_pop   = emit & ((q_rdata.op != OP_TAB) | tab_end);
  assign idx     = base_r + IW'(col_r);
  assign attr    = {bg_attr, fg_attr};

  // next row with wrap at the bottom
  always_comb begin
    if (row_r >= RW'(ROWS-1)) begin
      adv_row  = '0;
      adv_base = '0;
    end else begin
      adv_row  = row_r + 1'b1;
      adv_base = base_r + IW'(COLUMNS);
    end
  end

  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    base_nxt    = base_r;
    tab_cnt_nxt = tab_cnt_r;
    e_wr        = 1'b1;
    e_addr      = idx;
    e_ch        = q_rdata.ch;
    e_last      = 1'b1;
    case (q_rdata.op)
      OP_BS: begin
        e_ch = CH_SPACE;
        if (col_r == '0) begin
          e_wr   = 1'b0;
          e_addr = '0;
        end else begin
          col_nxt = col_r - 1'b1;
          e_addr  = idx - 1'b1;
        end
      end
      OP_LF: begin
        e_wr     = 1'b0;
        e_addr   = '0;
        col_nxt  = '0;
        row_nxt  = adv_row;
        base_nxt = adv_base;
      end
      default: begin
        // printable, or one space of a tab
        if (q_rdata.op == OP_TAB) begin
          e_ch        = CH_SPACE;
          e_last      = tab_end;
          tab_cnt_nxt = tab_end ? '0 : tab_cnt_r + 1'b1;
        end
        if (col_r == CW'(COLUMNS-1)) begin
          col_nxt  = '0;
          row_nxt  = adv_row;
          base_nxt = adv_base;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
    endcase
  end

  assign idx_after = base_nxt + IW'(col_nxt);
  assign addr_ext  = {{CELL_W{1'b0}}, e_addr};
  assign cur_ext   = {{CELL_W{1'b0}}, idx_after};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= RW'(2);
      col_r       <= '0;
      base_r      <= IW'(2 * COLUMNS);
      tab_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        row_r     <= row_nxt;
        col_r     <= col_nxt;
        base_r    <= base_nxt;
        tab_cnt_r <= tab_cnt_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      wr_r   <= e_wr;
      addr_r <= addr_ext[CELL_W-1:0];
      data_r <= e_wr ? {attr, e_ch} : '0;
      cur_r  <= cur_ext[CELL_W-1:0];
      last_r <= e_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_write   = wr_r;
  assign out_cell_address = addr_r;
  assign out_cell_data    = data_r;
  assign out_cursor_pos   = cur_r;
  assign out_last         = last_r;

`ifndef SYNTHESIS
  a_tab_cnt_only_in_tab: assert property (@(posedge clk) disable iff (!rst_n)
    (tab_cnt_r != '0) |-> (q_valid && q_rdata.op == OP_TAB))
    else $error("tab counter running without a tab at queue head");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < CW'(COLUMNS-1) || col_r == CW'(COLUMNS-1))
    else $error("column out of range");
  a_base_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    base_r == IW'(row_r * COLUMNS))
    else $error("row base out of step with row");
  a_tab_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && q_rdata.op == OP_TAB && !tab_end) |-> !q_pop)
    else $error("tab popped before its fourth space");
`endif

endmodule

// ===== src/text_console_char_writer_top.sv =====
// Top level of the text console character writer: config registers,
// front end, request queue, back end. Depends on tcw_pkg and all src modules.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_ready, in_char_code          | request in
//  result  | out_valid, out_ready, out_cell_* , ...    | request out
//  config  | psel, penable, pwrite, paddr, pwdata, ... | APB slave
//
// One result per cycle while requests wait and out_ready is high: printable,
// backspace, line feed one each, a tab one per space, paced by the result reg.
// NUL is swallowed by the front end and produces nothing.
// rst_n is synchronous; cursor resets to row 2, column 0, colors fg 7, bg 0.
// in_ready drops only when the 2-entry queue is full; out_ready stalls
// only the back end, so input keeps flowing until the queue fills.
module text_console_char_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  // input requests
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_code,
  // result requests
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_cell_write,
  output logic [CELL_W-1:0] out_cell_address,
  output logic [DATA_W-1:0] out_cell_data,
  output logic [CELL_W-1:0] out_cursor_pos,
  output logic              out_last,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [3:0] fg_r;
  logic [3:0] bg_r;
  logic       cfg_wr;

  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  // register select is address bit 2: 0x0 fg, 0x4 bg
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FG) begin
        fg_r <= pwdata[3:0];
      end else begin
        bg_r <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_FG) ? {28'd0, fg_r} : {28'd0, bg_r};

  tcw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .q_wdata      (q_wdata),
    .q_push       (q_push),
    .q_full       (q_full)
  );

  tcw_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .full   (q_full),
    .wdata  (q_wdata),
    .rvalid (q_valid),
    .rdata  (q_rdata),
    .pop    (q_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fg_attr          (fg_r),
    .bg_attr          (bg_r),
    .q_valid          (q_valid),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_write   (out_cell_write),
    .out_cell_address (out_cell_address),
    .out_cell_data    (out_cell_data),
    .out_cursor_pos   (out_cursor_pos),
    .out_last         (out_last)
  );

endmodule

// ===== bench/text_console_char_writer_top_tb.sv =====
// Self-checking bench for text_console_char_writer_top: random characters with a
// cursor-tracking scoreboard, color register writes over APB between phases.
// Depends on tcw_pkg and the RTL under src.
`timescale 1ns / 100ps

module text_console_char_writer_top_tb
  import tcw_pkg::*;
();

  localparam int SCR_COLS    = 80;
  localparam int SCR_ROWS    = 25;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 20;   // queue plus back end, with margin
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int MAX_REPORTS = 10;

  // one result request as seen on the out_ channel
  typedef struct packed {
    logic              wr;
    logic [CELL_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [CELL_W-1:0] cursor;
    logic              last;
  } result_t;

  // Tracks cursor and colors, expands each accepted character into the
  // result requests it must cause, and checks them in order.
  class tcw_scoreboard;
    result_t    pending_q[$];
    logic [3:0] fg;
    logic [3:0] bg;
    logic [4:0] row;
    logic [6:0] col;
    int         errors;

    function new();
      fg     = FG_RESET;
      bg     = BG_RESET;
      row    = 5'd2;
      col    = 7'd0;
      errors = 0;
    endfunction

    function void set_color(logic reg_sel, logic [3:0] value);
      if (reg_sel == REG_FG) begin
        fg = value;
      end else begin
        bg = value;
      end
    endfunction

    function logic [CELL_W-1:0] cursor_index();
      return CELL_W'(int'(row) * SCR_COLS + int'(col));
    endfunction

    function logic [DATA_W-1:0] cell_word(logic [7:0] ch);
      return {bg, fg, ch};
    endfunction

    function void queue_result(logic wr, logic [CELL_W-1:0] addr,
                               logic [DATA_W-1:0] data, logic last);
      result_t r;
      r.wr     = wr;
      r.addr   = addr;
      r.data   = data;
      r.cursor = cursor_index();
      r.last   = last;
      pending_q.push_back(r);
    endfunction

    function void next_row();
      if (int'(row) + 1 >= SCR_ROWS) begin
        row = '0;
      end else begin
        row = row + 5'd1;
      end
    endfunction

    function void put_char(logic [7:0] ch, logic last);
      logic [CELL_W-1:0] addr;
      logic [DATA_W-1:0] data;
      addr = cursor_index();
      data = cell_word(ch);
      if (int'(col) + 1 >= SCR_COLS) begin
        col = '0;
        next_row();
      end else begin
        col = col + 7'd1;
      end
      queue_result(1'b1, addr, data, last);
    endfunction

    // called once per accepted input request
    function void note_char(logic [7:0] ch);
      case (ch)
        CH_NUL: begin
        end
        CH_BS: begin
          if (col == 0) begin
            queue_result(1'b0, '0, '0, 1'b1);
          end else begin
            col = col - 7'd1;
            queue_result(1'b1, cursor_index(), cell_word(CH_SPACE), 1'b1);
          end
        end
        CH_LF: begin
          col = '0;
          next_row();
          queue_result(1'b0, '0, '0, 1'b1);
        end
        CH_TAB: begin
          for (int i = 0; i < TAB_SPACES; i++) begin
            put_char(CH_SPACE, i == TAB_SPACES - 1);
          end
        end
        default: put_char(ch, 1'b1);
      endcase
    endfunction

    // called once per accepted result request
    function void check_result(result_t got);
      result_t exp_r;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected result: wr %0d addr %0d data %h cursor %0d last %0d",
                   got.wr, got.addr, got.data, got.cursor, got.last);
        end
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.wr !== exp_r.wr || got.addr !== exp_r.addr || got.data !== exp_r.data ||
          got.cursor !== exp_r.cursor || got.last !== exp_r.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch exp: wr %0d addr %0d data %h cursor %0d last %0d",
                   exp_r.wr, exp_r.addr, exp_r.data, exp_r.cursor, exp_r.last);
          $display("         got: wr %0d addr %0d data %h cursor %0d last %0d",
                   got.wr, got.addr, got.data, got.cursor, got.last);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_char_code = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_cell_write;
  logic [CELL_W-1:0] out_cell_address;
  logic [DATA_W-1:0] out_cell_data;
  logic [CELL_W-1:0] out_cursor_pos;
  logic              out_last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = 3'd0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  tcw_scoreboard screen_sb;
  bit            idle_on = 1'b1;  // random gaps on both channels
  bit            hold_req = 1'b0; // asks the receiver for one long hold-off
  int            cycle_count = 0;

  // reset-time directed characters: backspace at column 0 first, then
  // byte extremes, a carriage return, tabs, backspaces and line feeds
  logic [7:0] directed_chars [21] = '{
    CH_BS, 8'h41, 8'hFF, 8'h01, CH_NUL, 8'h80, 8'h7F, 8'h0D, CH_TAB, CH_BS, CH_BS,
    CH_LF, CH_TAB, CH_TAB, CH_BS, CH_SPACE, 8'h0B, CH_LF, CH_BS, 8'hAA, 8'h55
  };

  text_console_char_writer_top #(
    .COLUMNS(SCR_COLS),
    .ROWS   (SCR_ROWS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cell_write  (out_cell_write),
    .out_cell_address(out_cell_address),
    .out_cell_data   (out_cell_data),
    .out_cursor_pos  (out_cursor_pos),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor: values read here are the ones before this edge
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.wr     = out_cell_write;
      got.addr   = out_cell_address;
      got.data   = out_cell_data;
      got.cursor = out_cursor_pos;
      got.last   = out_last;
      screen_sb.check_result(got);
    end
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request so the
  // internal queue fills and in_ready drops
  initial begin
    int stall;
    int burst;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        burst = $urandom_range(1, 8);
        repeat (burst) @(posedge clk);
      end
    end
  end

  // Offers one character request and returns at the edge that accepts it.
  // Valid stays up between back-to-back requests.
  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    do @(posedge clk); while (!in_ready);
    screen_sb.note_char(ch);
  endtask

  // Drop valid and wait until every expected result is in, then wait out
  // DRAIN_WAIT as well; a NUL never reaches the queue and expects nothing.
  task automatic drain();
    in_valid <= 1'b0;
    while (screen_sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // APB write of one color register, then a read-back
  task automatic write_color(input logic reg_sel, input logic [3:0] value);
    logic [31:0] word;
    word = {28'($urandom_range(0, 32'h0FFF_FFFF)), value};  // upper bits must be dropped
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    screen_sb.set_color(reg_sel, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {28'd0, value}) begin
      screen_sb.errors++;
      if (screen_sb.errors <= MAX_REPORTS) begin
        $display("register %0d read back %h, expected %h", reg_sel, prdata, value);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] mixed_char();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return CH_NUL;
      1, 2:    return CH_BS;
      3, 4:    return CH_TAB;
      5, 6:    return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random requests in segments: mixed text, tab runs that wrap the line,
  // line feed bursts that wrap the screen, backspace bursts past column 0.
  // NULs do not count toward n_chars.
  task automatic run_random(input int n_chars);
    int         sent;
    int         seg;
    int         len;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_chars) begin
      seg = $urandom_range(0, 99);
      if (seg < 55) begin
        len = $urandom_range(5, 20);
      end else if (seg < 70) begin
        len = $urandom_range(15, 25);
      end else if (seg < 85) begin
        len = $urandom_range(5, 25);
      end else begin
        len = $urandom_range(1, 10);
      end
      repeat (len) begin
        if (seg < 55) begin
          ch = mixed_char();
        end else if (seg < 70) begin
          ch = CH_TAB;
        end else if (seg < 85) begin
          ch = CH_LF;
        end else begin
          ch = CH_BS;
        end
        send_char(ch);
        if (ch != CH_NUL) begin
          sent++;
        end
      end
    end
  endtask

  initial begin
    screen_sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 0: colors from reset
    foreach (directed_chars[i]) begin
      send_char(directed_chars[i]);
    end
    run_random(60);
    drain();

    // phase 1: colors at the top, no idling, long receiver hold-off
    write_color(REG_FG, 4'hF);
    write_color(REG_BG, 4'hF);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    run_random(70);
    drain();
    idle_on = 1'b1;

    // phase 2: colors at zero
    write_color(REG_FG, 4'h0);
    write_color(REG_BG, 4'h0);
    run_random(70);
    drain();

    // phase 3: random colors
    write_color(REG_FG, 4'($urandom_range(0, 15)));
    write_color(REG_BG, 4'($urandom_range(0, 15)));
    run_random(80);
    drain();

    if (screen_sb.errors == 0 && screen_sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== text_console_char_writer_top.f =====
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_fifo.sv
src/tcw_back.sv
src/text_console_char_writer_top.sv
bench/text_console_char_writer_top_tb.sv
